// ----- sv/kog_pkg.sv -----
// ----------------------------------------------------------------------------
// Keyspace odometer generator package
// Shared constants, command codes, queue entry and configuration types.
// ----------------------------------------------------------------------------
package kog_pkg;

  // Candidate geometry.
  localparam int MAX_LEN    = 16;
  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = $clog2(MAX_LEN);
  localparam int LEN_W      = 5;
  localparam int SYM_W      = 8;
  localparam int ADDR_W     = $clog2(TABLE_SIZE);
  localparam int CNT_W      = 9;
  localparam int POS_W      = 4;

  // Reset values of the configuration registers.
  localparam logic [LEN_W-1:0] RESET_LEN   = LEN_W'(3);
  localparam logic [CNT_W-1:0] RESET_COUNT = CNT_W'(36);

  // Depth of the command queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // Command codes as seen on the input channel.
  localparam logic [1:0] CMD_NEXT    = 2'd0;
  localparam logic [1:0] CMD_LOAD    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_MIN_LEN      = 2'd0;
  localparam logic [1:0] REG_MAX_LEN      = 2'd1;
  localparam logic [1:0] REG_SYMBOL_COUNT = 2'd2;

  typedef enum logic [1:0] {
    OP_NEXT,
    OP_LOAD,
    OP_RESTART
  } kog_op_t;

  typedef struct packed {
    kog_op_t           op;
    logic [ADDR_W-1:0] sym_index;
    logic [SYM_W-1:0]  sym_byte;
  } kog_entry_t;

  // Effective configuration after clamping.
  typedef struct packed {
    logic [LEN_W-1:0] min_len;
    logic [LEN_W-1:0] max_len;
    logic [CNT_W-1:0] radix;
  } kog_cfg_t;

  // Reset contents of the symbol table: a to z, then 0 to 9, then zero.
  function automatic logic [SYM_W-1:0] default_symbol(input logic [ADDR_W-1:0] addr);
    logic [SYM_W-1:0] sym;
    sym = '0;
    if (int'(addr) < 26) begin
      sym = SYM_W'(8'h61 + int'(addr));
    end else if (int'(addr) < 36) begin
      sym = SYM_W'(8'h30 + int'(addr) - 26);
    end
    return sym;
  endfunction

endpackage

// ----- sv/keyspace_odometer_generator_top.sv -----
// ----------------------------------------------------------------------------
// Keyspace odometer generator, top level
// Enumerates all strings over a loadable symbol table, length by length.
// ----------------------------------------------------------------------------
// The first symbol of a next word passes through the command queue, the table
// read and the output register. A candidate of length L then leaves at one
// symbol per cycle while the output is not stalled. A next word occupies the
// back end through emission and the carry ripple, which visits one digit per
// cycle; loads and restarts are done from the idle state. The command queue holds four words.
// Reset is synchronous and active low; the symbol table reads a to z, 0 to 9
// straight away through per-slot valid bits, so there is no clearing pass.
// ----------------------------------------------------------------------------
module keyspace_odometer_generator_top (
  input  logic        clk,
  input  logic        rst_n,
  // Input words.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] sym_index, [15:8] sym_byte
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  // Result words.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] symbol, [11:8] position, [15:12] zero
  output logic        out_tlast,  // last_symbol
  output logic [0:0]  out_tuser,  // [0] exhausted
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int LEN_W = kog_pkg::LEN_W;
  localparam int CNT_W = kog_pkg::CNT_W;

  // Raw register values as written.
  logic [LEN_W-1:0] min_len_r, min_len_nxt;
  logic [LEN_W-1:0] max_len_r, max_len_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  kog_pkg::kog_cfg_t   cfg_eff;
  logic [LEN_W-1:0]    eff_min;
  logic                q_valid;
  logic                q_pop;
  kog_pkg::kog_entry_t q_entry;
  logic [kog_pkg::SYM_W-1:0] out_symbol;
  logic [kog_pkg::POS_W-1:0] out_position;

  // The register file takes a write in every cycle.
  assign cfg_ready = 1'b1;

  always_comb begin
    min_len_nxt = min_len_r;
    max_len_nxt = max_len_r;
    count_nxt   = count_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        kog_pkg::REG_MIN_LEN:      min_len_nxt = cfg_data[LEN_W-1:0];
        kog_pkg::REG_MAX_LEN:      max_len_nxt = cfg_data[LEN_W-1:0];
        kog_pkg::REG_SYMBOL_COUNT: count_nxt   = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= kog_pkg::RESET_LEN;
      max_len_r <= kog_pkg::RESET_LEN;
      count_r   <= kog_pkg::RESET_COUNT;
    end else begin
      min_len_r <= min_len_nxt;
      max_len_r <= max_len_nxt;
      count_r   <= count_nxt;
    end
  end

  // Clamp the registers: lengths into one to the longest candidate, the
  // maximum no lower than the minimum, and the radix into one to the table
  // size. Only the clamped values reach the back end.
  always_comb begin
    eff_min = min_len_r;
    if (min_len_r == '0) begin
      eff_min = LEN_W'(1);
    end else if (min_len_r > LEN_W'(kog_pkg::MAX_LEN)) begin
      eff_min = LEN_W'(kog_pkg::MAX_LEN);
    end

    cfg_eff.min_len = eff_min;
    cfg_eff.max_len = max_len_r;
    if (max_len_r < eff_min) begin
      cfg_eff.max_len = eff_min;
    end else if (max_len_r > LEN_W'(kog_pkg::MAX_LEN)) begin
      cfg_eff.max_len = LEN_W'(kog_pkg::MAX_LEN);
    end

    cfg_eff.radix = count_r;
    if (count_r == '0) begin
      cfg_eff.radix = CNT_W'(1);
    end else if (count_r > CNT_W'(kog_pkg::TABLE_SIZE)) begin
      cfg_eff.radix = CNT_W'(kog_pkg::TABLE_SIZE);
    end
  end

  // Front end: takes words, drops unused codes and queues the rest.
  kog_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .cmd       (in_tuser),
    .sym_index (in_tdata[7:0]),
    .sym_byte  (in_tdata[15:8]),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop)
  );

  // Back end: owns the symbol table, the digits and the output register.
  kog_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_eff),
    .q_valid       (q_valid),
    .q_entry       (q_entry),
    .q_pop         (q_pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_symbol    (out_symbol),
    .out_position  (out_position),
    .out_last      (out_tlast),
    .out_exhausted (out_tuser[0])
  );

  assign out_tdata = {4'b0000, out_position, out_symbol};

endmodule

// ----- sv/kog_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module kog_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/kog_front.sv -----
// ----------------------------------------------------------------------------
// Keyspace odometer front end
// Accepts command words, sorts them into operations and queues them.
// ----------------------------------------------------------------------------
module kog_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     cmd,
  input  logic [kog_pkg::ADDR_W-1:0]     sym_index,
  input  logic [kog_pkg::SYM_W-1:0]      sym_byte,
  output logic                           q_valid,
  output kog_pkg::kog_entry_t            q_entry,
  input  logic                           q_pop
);

  localparam int PTR_W   = $clog2(kog_pkg::QUEUE_DEPTH);
  localparam int COUNT_W = $clog2(kog_pkg::QUEUE_DEPTH + 1);

  kog_pkg::kog_entry_t mem_r [kog_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;

  kog_pkg::kog_op_t    op;
  logic                keep;
  logic                push;
  logic                pop;

  // Unused command codes are accepted and dropped here.
  always_comb begin
    op   = kog_pkg::OP_NEXT;
    keep = 1'b1;
    unique case (cmd)
      kog_pkg::CMD_NEXT:    op = kog_pkg::OP_NEXT;
      kog_pkg::CMD_LOAD:    op = kog_pkg::OP_LOAD;
      kog_pkg::CMD_RESTART: op = kog_pkg::OP_RESTART;
      default:              keep = 1'b0;
    endcase
  end

  assign in_ready = (count_r != COUNT_W'(kog_pkg::QUEUE_DEPTH));
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_entry  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{op: op, sym_index: sym_index, sym_byte: sym_byte};
    end
  end

endmodule

// ----- sv/kog_back.sv -----
// ----------------------------------------------------------------------------
// Keyspace odometer back end
// Executes queued operations: table loads, restarts and candidate emission.
// ----------------------------------------------------------------------------
module kog_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kog_pkg::kog_cfg_t             cfg,
  input  logic                          q_valid,
  input  kog_pkg::kog_entry_t           q_entry,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kog_pkg::SYM_W-1:0]     out_symbol,
  output logic [kog_pkg::POS_W-1:0]     out_position,
  output logic                          out_last,
  output logic                          out_exhausted
);

  localparam int IDX_W  = kog_pkg::IDX_W;
  localparam int LEN_W  = kog_pkg::LEN_W;
  localparam int SYM_W  = kog_pkg::SYM_W;
  localparam int ADDR_W = kog_pkg::ADDR_W;
  localparam int CNT_W  = kog_pkg::CNT_W;
  localparam int POS_W  = kog_pkg::POS_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_CARRY,
    ST_EXH
  } state_t;

  state_t                 state_r, state_nxt;
  logic [SYM_W-1:0]       digits_r [kog_pkg::MAX_LEN];
  logic [SYM_W-1:0]       digits_nxt [kog_pkg::MAX_LEN];
  logic [LEN_W-1:0]       cur_len_r, cur_len_nxt;
  logic                   done_r, done_nxt;
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [kog_pkg::TABLE_SIZE-1:0] vld_r, vld_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  logic [ADDR_W-1:0]      rd_addr_r, rd_addr_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]       out_symbol_r, out_symbol_nxt;
  logic [POS_W-1:0]       out_position_r, out_position_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_exhausted_r, out_exhausted_nxt;

  logic                   ram_we;
  logic                   ram_re;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [SYM_W-1:0]       ram_rdata;

  logic                   can_load;
  logic                   is_last;
  logic [SYM_W-1:0]       rd_symbol;
  logic [CNT_W-1:0]       full;
  logic [LEN_W-1:0]       clamped_len;
  logic [LEN_W-1:0]       grown_len;
  logic [IDX_W-1:0]       next_idx;

  kog_ram #(
    .WIDTH (SYM_W),
    .DEPTH (kog_pkg::TABLE_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_entry.sym_index),
    .wdata (q_entry.sym_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Slots never loaded read as their reset contents.
  assign rd_symbol = rd_vld_r ? ram_rdata : kog_pkg::default_symbol(rd_addr_r);
  assign can_load  = !out_valid_r || out_ready;
  assign is_last   = ((LEN_W'(idx_r) + 1'b1) == len_r);
  assign full      = cfg.radix - 1'b1;
  assign grown_len = len_r + 1'b1;
  assign next_idx  = idx_r + 1'b1;

  always_comb begin
    clamped_len = cur_len_r;
    if (cur_len_r == '0) begin
      clamped_len = LEN_W'(1);
    end else if (cur_len_r > LEN_W'(kog_pkg::MAX_LEN)) begin
      clamped_len = LEN_W'(kog_pkg::MAX_LEN);
    end
  end

  always_comb begin
    state_nxt         = state_r;
    digits_nxt        = digits_r;
    cur_len_nxt       = cur_len_r;
    done_nxt          = done_r;
    len_nxt           = len_r;
    idx_nxt           = idx_r;
    vld_nxt           = vld_r;
    rd_vld_nxt        = rd_vld_r;
    rd_addr_nxt       = rd_addr_r;
    out_valid_nxt     = out_valid_r;
    out_symbol_nxt    = out_symbol_r;
    out_position_nxt  = out_position_r;
    out_last_nxt      = out_last_r;
    out_exhausted_nxt = out_exhausted_r;
    q_pop             = 1'b0;
    ram_we            = 1'b0;
    ram_re            = 1'b0;
    ram_raddr         = digits_r[0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_entry.op)
            kog_pkg::OP_LOAD: begin
              ram_we                     = 1'b1;
              vld_nxt[q_entry.sym_index] = 1'b1;
            end
            kog_pkg::OP_RESTART: begin
              for (int i = 0; i < kog_pkg::MAX_LEN; i++) begin
                digits_nxt[i] = '0;
              end
              cur_len_nxt = cfg.min_len;
              done_nxt    = 1'b0;
            end
            kog_pkg::OP_NEXT: begin
              if (done_r) begin
                state_nxt = ST_EXH;
              end else begin
                len_nxt     = clamped_len;
                idx_nxt     = '0;
                ram_re      = 1'b1;
                ram_raddr   = digits_r[0];
                rd_vld_nxt  = vld_r[digits_r[0]];
                rd_addr_nxt = digits_r[0];
                state_nxt   = ST_EMIT;
              end
            end
            default: ;
          endcase
        end
      end

      ST_EMIT: begin
        if (can_load) begin
          out_valid_nxt     = 1'b1;
          out_symbol_nxt    = rd_symbol;
          out_position_nxt  = POS_W'(idx_r);
          out_last_nxt      = is_last;
          out_exhausted_nxt = 1'b0;
          if (is_last) begin
            state_nxt = ST_CARRY;
          end else begin
            idx_nxt     = next_idx;
            ram_re      = 1'b1;
            ram_raddr   = digits_r[next_idx];
            rd_vld_nxt  = vld_r[digits_r[next_idx]];
            rd_addr_nxt = digits_r[next_idx];
          end
        end
      end

      // Ripple the carry from the rightmost position, one position a cycle.
      ST_CARRY: begin
        if ({1'b0, digits_r[idx_r]} >= full) begin
          digits_nxt[idx_r] = '0;
          if (idx_r == '0) begin
            cur_len_nxt = grown_len;
            if (grown_len > cfg.max_len) begin
              done_nxt = 1'b1;
            end
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end else begin
          digits_nxt[idx_r] = digits_r[idx_r] + 1'b1;
          state_nxt         = ST_IDLE;
        end
      end

      ST_EXH: begin
        if (can_load) begin
          out_valid_nxt     = 1'b1;
          out_symbol_nxt    = '0;
          out_position_nxt  = '0;
          out_last_nxt      = 1'b1;
          out_exhausted_nxt = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // Carry phase starts at the rightmost position.
    if (state_r == ST_EMIT && can_load && is_last) begin
      idx_nxt = IDX_W'(len_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      for (int i = 0; i < kog_pkg::MAX_LEN; i++) begin
        digits_r[i] <= '0;
      end
      cur_len_r       <= kog_pkg::RESET_LEN;
      done_r          <= 1'b0;
      len_r           <= kog_pkg::RESET_LEN;
      idx_r           <= '0;
      vld_r           <= '0;
      rd_vld_r        <= 1'b0;
      rd_addr_r       <= '0;
      out_valid_r     <= 1'b0;
      out_symbol_r    <= '0;
      out_position_r  <= '0;
      out_last_r      <= 1'b0;
      out_exhausted_r <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      digits_r        <= digits_nxt;
      cur_len_r       <= cur_len_nxt;
      done_r          <= done_nxt;
      len_r           <= len_nxt;
      idx_r           <= idx_nxt;
      vld_r           <= vld_nxt;
      rd_vld_r        <= rd_vld_nxt;
      rd_addr_r       <= rd_addr_nxt;
      out_valid_r     <= out_valid_nxt;
      out_symbol_r    <= out_symbol_nxt;
      out_position_r  <= out_position_nxt;
      out_last_r      <= out_last_nxt;
      out_exhausted_r <= out_exhausted_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_symbol    = out_symbol_r;
  assign out_position  = out_position_r;
  assign out_last      = out_last_r;
  assign out_exhausted = out_exhausted_r;

endmodule

// ----- sv/kog_checker.sv -----
// ----------------------------------------------------------------------------
// Keyspace odometer port checker
// Watches the top-level ports and flags inconsistent result words.
// ----------------------------------------------------------------------------
module kog_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic [0:0]  out_tuser
);

  // An exhausted word always closes its run.
  a_exh_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tlast)
    else $error("exhausted word without last marker");

  // An exhausted word carries symbol zero at position zero.
  a_exh_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == 16'h0000))
    else $error("exhausted word carries data");

  // Padding above the position field stays clear.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:12] == 4'h0))
    else $error("padding bits set in result word");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser)))
    else $error("stalled result word changed");

endmodule

bind keyspace_odometer_generator_top kog_checker u_kog_checker (.*);

// ----- test/keyspace_odometer_generator_top_test.sv -----
// ----------------------------------------------------------------------------
// Keyspace odometer generator testbench
// Drives next, load, restart and unused command words into the generator,
// across a series of length and radix settings, and predicts every symbol
// word that comes back. Each result word is compared field by field with the
// oldest predicted word, under random idling on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module keyspace_odometer_generator_top_test;

  // Codes that the package leaves unnamed.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] REG_SPARE  = 2'd3;

  // Length of the quiet period that lets the command queue empty out after
  // the last predicted word, with room for four queued words.
  localparam int QUIET_CYCLES = 200;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] idx;
    logic [7:0] byt;
  } cmd_word_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic [3:0] position;
    logic       last_symbol;
    logic       exhausted;
  } cand_sym_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic [0:0]  out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = '0;
  logic [8:0]  cfg_data   = '0;

  // Command words waiting for the driver, and symbol words still owed.
  cmd_word_t pending_words[$];
  cand_sym_t expected_syms[$];

  // Our own copy of the generator: registers, odometer and symbol table.
  logic [4:0] reg_min;
  logic [4:0] reg_max;
  logic [8:0] reg_count;
  logic [7:0] odo_digit [kog_pkg::MAX_LEN];
  int         odo_len;
  logic       odo_done;
  logic [7:0] sym_table [kog_pkg::TABLE_SIZE];

  int        mismatches  = 0;
  int        random_sent = 0;
  logic      steady      = 1'b0;  // when set, neither side idles
  cmd_word_t drv_word;
  cand_sym_t want;

  keyspace_odometer_generator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] sym_index, [15:8] sym_byte
    .in_tuser   (in_tuser),   // [1:0] cmd
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [7:0] symbol, [11:8] position, [15:12] zero
    .out_tlast  (out_tlast),  // last_symbol
    .out_tuser  (out_tuser),  // [0] exhausted
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Shortest length in force: zero counts as one, anything above the
  // longest supported length saturates.
  function automatic int shortest_len();
    int lo;
    lo = int'(reg_min);
    if (lo < 1) lo = 1;
    if (lo > kog_pkg::MAX_LEN) lo = kog_pkg::MAX_LEN;
    return lo;
  endfunction

  function automatic void restart_odometer();
    int i;
    for (i = 0; i < kog_pkg::MAX_LEN; i++) odo_digit[i] = '0;
    odo_len  = shortest_len();
    odo_done = 1'b0;
  endfunction

  function automatic void reset_generator();
    int i;
    reg_min   = kog_pkg::RESET_LEN;
    reg_max   = kog_pkg::RESET_LEN;
    reg_count = kog_pkg::RESET_COUNT;
    for (i = 0; i < kog_pkg::TABLE_SIZE; i++) sym_table[i] = 8'h00;
    for (i = 0; i < 26; i++) sym_table[i] = 8'(8'h61 + i);
    for (i = 0; i < 10; i++) sym_table[26 + i] = 8'(8'h30 + i);
    restart_odometer();
  endfunction

  // Applies one accepted command word and queues the symbol words it owes.
  function automatic void odometer_step(input logic [1:0] cmd, input logic [7:0] idx,
                                        input logic [7:0] byt);
    int        hi;
    int        radix;
    int        len;
    int        pos;
    int        i;
    cand_sym_t s;
    if (cmd == kog_pkg::CMD_LOAD) begin
      sym_table[idx] = byt;
    end else if (cmd == kog_pkg::CMD_RESTART) begin
      restart_odometer();
    end else if (cmd == kog_pkg::CMD_NEXT) begin
      if (odo_done) begin
        s.symbol      = 8'h00;
        s.position    = 4'h0;
        s.last_symbol = 1'b1;
        s.exhausted   = 1'b1;
        expected_syms.push_back(s);
      end else begin
        // A longest length below the shortest one is lifted to it.
        hi = int'(reg_max);
        if (hi < shortest_len()) hi = shortest_len();
        if (hi > kog_pkg::MAX_LEN) hi = kog_pkg::MAX_LEN;
        radix = int'(reg_count);
        if (radix < 1) radix = 1;
        if (radix > kog_pkg::TABLE_SIZE) radix = kog_pkg::TABLE_SIZE;
        len = odo_len;
        if (len < 1) len = 1;
        if (len > kog_pkg::MAX_LEN) len = kog_pkg::MAX_LEN;
        for (i = 0; i < len; i++) begin
          s.symbol      = sym_table[odo_digit[i]];
          s.position    = 4'(i);
          s.last_symbol = (i == len - 1);
          s.exhausted   = 1'b0;
          expected_syms.push_back(s);
        end
        // Carry from the right. A digit left beyond a shrunken radix counts
        // as full and wraps just like one sitting at radix minus one.
        pos = len - 1;
        while (pos >= 0 && int'(odo_digit[pos]) >= radix - 1) begin
          odo_digit[pos] = '0;
          pos--;
        end
        if (pos >= 0) begin
          odo_digit[pos] = odo_digit[pos] + 8'd1;
        end else begin
          odo_len = len + 1;
          if (odo_len > hi) odo_done = 1'b1;
        end
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers queued command words, idling at random. A word is applied
  // to the prediction at the edge where it is taken.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        odometer_step(in_tuser, in_tdata[7:0], in_tdata[15:8]);
      end
      if (!in_tvalid || in_tready) begin
        if (pending_words.size() != 0 && (steady || $urandom_range(0, 99) >= 10)) begin
          drv_word = pending_words.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= drv_word.cmd;
          in_tdata  <= {drv_word.byt, drv_word.idx};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: stalls at random and checks every result word taken.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_syms.size() == 0) begin
          $error("unexpected result word: tdata %h, tlast %b, tuser %b",
                 out_tdata, out_tlast, out_tuser);
          mismatches++;
        end else begin
          want = expected_syms.pop_front();
          if (out_tdata[7:0] !== want.symbol) begin
            $error("symbol: expected %h, actual %h", want.symbol, out_tdata[7:0]);
            mismatches++;
          end
          if (out_tdata[11:8] !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, out_tdata[11:8]);
            mismatches++;
          end
          if (out_tdata[15:12] !== 4'h0) begin
            $error("tdata padding: expected 0, actual %h", out_tdata[15:12]);
            mismatches++;
          end
          if (out_tlast !== want.last_symbol) begin
            $error("last_symbol: expected %b, actual %b", want.last_symbol, out_tlast);
            mismatches++;
          end
          if (out_tuser[0] !== want.exhausted) begin
            $error("exhausted: expected %b, actual %b", want.exhausted, out_tuser[0]);
            mismatches++;
          end
        end
      end
      out_tready <= steady || ($urandom_range(0, 99) >= 10);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic send(input logic [1:0] cmd, input logic [7:0] idx, input logic [7:0] byt);
    cmd_word_t w;
    w.cmd = cmd;
    w.idx = idx;
    w.byt = byt;
    pending_words.push_back(w);
  endtask

  task automatic send_nexts(input int n);
    int i;
    for (i = 0; i < n; i++) send(kog_pkg::CMD_NEXT, 8'($urandom), 8'($urandom));
  endtask

  // Mostly next words with random unused fields; loads favour the low slots
  // so that they land inside small radices.
  task automatic send_random_word();
    int         roll;
    logic [7:0] slot;
    roll = $urandom_range(0, 99);
    slot = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    if (roll < 72) begin
      send(kog_pkg::CMD_NEXT, 8'($urandom), 8'($urandom));
    end else if (roll < 86) begin
      send(kog_pkg::CMD_LOAD, slot, 8'($urandom));
    end else if (roll < 93) begin
      send(kog_pkg::CMD_RESTART, 8'($urandom), 8'($urandom));
    end else begin
      send(CMD_UNUSED, 8'($urandom), 8'($urandom));
    end
    random_sent++;
  endtask

  // Register writes go out only while the generator is idle.
  task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == kog_pkg::REG_MIN_LEN) reg_min = val[4:0];
    else if (idx == kog_pkg::REG_MAX_LEN) reg_max = val[4:0];
    else if (idx == kog_pkg::REG_SYMBOL_COUNT) reg_count = val;
  endtask

  task automatic write_setting(input logic [8:0] lo, input logic [8:0] hi,
                               input logic [8:0] cnt);
    write_reg(kog_pkg::REG_MIN_LEN, lo);
    write_reg(kog_pkg::REG_MAX_LEN, hi);
    write_reg(kog_pkg::REG_SYMBOL_COUNT, cnt);
  endtask

  // Waits on settled values until every word has gone in and every owed
  // symbol has come out, then lets any trailing load or restart finish.
  task automatic settle();
    @(negedge clk);
    while (pending_words.size() != 0 || in_tvalid || expected_syms.size() != 0) begin
      @(negedge clk);
    end
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int         i;
    int         phase;
    logic [4:0] lo;
    logic [4:0] hi;
    logic [8:0] cnt;

    reset_generator();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting: three letter candidates over a to z and 0 to 9. Loads at
    // both ends of the table and of the byte range, an unused command and a
    // restart in between.
    send_nexts(3);
    send(kog_pkg::CMD_LOAD, 8'h00, 8'hFF);
    send(kog_pkg::CMD_LOAD, 8'hFF, 8'h00);
    send_nexts(1);
    send(CMD_UNUSED, 8'hFF, 8'hFF);
    send(kog_pkg::CMD_RESTART, 8'h00, 8'h00);
    send_nexts(1);
    settle();

    // Two symbols, lengths one and two: growth of the length, exhaustion,
    // repeated exhausted answers and recovery through a restart.
    write_setting(9'd1, 9'd2, 9'd2);
    send(kog_pkg::CMD_RESTART, 8'h00, 8'h00);
    send_nexts(8);
    send(kog_pkg::CMD_RESTART, 8'h00, 8'h00);
    send_nexts(1);
    settle();

    // All registers zero: length one, radix one, exhausted after one word.
    write_setting(9'd0, 9'd0, 9'd0);
    send(kog_pkg::CMD_RESTART, 8'h00, 8'h00);
    send_nexts(2);
    settle();

    // All bits set: every value saturates; the spare index is ignored.
    write_setting(9'h1FF, 9'h1FF, 9'h1FF);
    write_reg(REG_SPARE, 9'h1FF);
    send(kog_pkg::CMD_RESTART, 8'h00, 8'h00);
    send_nexts(2);
    settle();

    // Top of the legal ranges.
    write_setting(9'd16, 9'd16, 9'd256);
    send(kog_pkg::CMD_RESTART, 8'h00, 8'h00);
    send_nexts(2);
    settle();

    // Longest length below the shortest: it is lifted to the shortest.
    write_setting(9'd3, 9'd1, 9'd2);
    send(kog_pkg::CMD_RESTART, 8'h00, 8'h00);
    send_nexts(9);
    settle();

    // Shrinking the radix under live digits: digits beyond it wrap at once.
    write_setting(9'd2, 9'd3, 9'd36);
    send(kog_pkg::CMD_RESTART, 8'h00, 8'h00);
    send_nexts(5);
    settle();
    write_reg(kog_pkg::REG_SYMBOL_COUNT, 9'd3);
    send_nexts(12);
    settle();

    // Random phases. Most settings are small enough for the odometer to run
    // through every length and exhaust; some are drawn from the full range.
    phase = 0;
    while (random_sent < 240) begin
      if ($urandom_range(0, 4) == 0) begin
        lo  = 5'($urandom);
        hi  = 5'($urandom);
        cnt = 9'($urandom);
      end else begin
        lo  = 5'($urandom_range(0, 4));
        hi  = 5'($urandom_range(0, 5));
        cnt = 9'($urandom_range(0, 4));
      end
      // The upper data bits carry noise that the length registers drop.
      write_setting({4'($urandom), lo}, {4'($urandom), hi}, cnt);
      if ($urandom_range(0, 4) != 0) begin
        send(kog_pkg::CMD_RESTART, 8'($urandom), 8'($urandom));
      end
      // One phase runs with no idling on either side.
      @(negedge clk);
      steady = (phase == 3);
      for (i = 0; i < 40; i++) send_random_word();
      settle();
      @(negedge clk);
      steady = 1'b0;
      phase++;
    end

    settle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Safety net well beyond the slowest correct run.
  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/kog_pkg.sv
sv/kog_ram.sv
sv/kog_front.sv
sv/kog_back.sv
sv/keyspace_odometer_generator_top.sv
sv/kog_checker.sv
test/keyspace_odometer_generator_top_test.sv
